### design/jfos_pkg.sv
// ----------------------------------------------------------------------------
// jfos_pkg
// Shared constants and types of the frame operand stack unit: array sizes,
// operation and error codes, and the controller command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jfos_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LOCAL_SLOTS = 16;

  // Index widths of the two register files.
  localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LIDX_W = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
  // Depth counter holds 0..STACK_DEPTH.
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  // Width used for limit compares; wide enough for any depth or slot count.
  localparam int CMP_W = 9;

  localparam int VAL_W = 64;
  localparam int TAG_W = 4;
  localparam int CFG_W = 5;

  localparam logic [2:0] MODE_PUSH   = 3'd0;
  localparam logic [2:0] MODE_PUSHOB = 3'd1;
  localparam logic [2:0] MODE_POP    = 3'd2;
  localparam logic [2:0] MODE_DUP    = 3'd3;
  localparam logic [2:0] MODE_LOAD   = 3'd4;
  localparam logic [2:0] MODE_STORE  = 3'd5;
  localparam logic [2:0] MODE_READ   = 3'd6;
  localparam logic [2:0] MODE_NOP    = 3'd7;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_OVER  = 2'd1;
  localparam logic [1:0] ERR_UNDER = 2'd2;
  localparam logic [1:0] ERR_SLOT  = 2'd3;

  localparam logic [TAG_W-1:0] TAG_OBJECT = 4'd1;

  // Register indexes of the configuration port.
  localparam logic REG_LOCAL_COUNT = 1'b0;
  localparam logic REG_STACK_LIMIT = 1'b1;

  typedef struct packed {
    logic capture;   // latch the incoming operation
    logic execute;   // perform the latched operation and post its result
  } jfos_cmd_t;

endpackage : jfos_pkg

`default_nettype wire

### design/jfos_ctrl.sv
// ----------------------------------------------------------------------------
// jfos_ctrl
// Two-state sequencer: captures one operation, then executes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jfos_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  output jfos_pkg::jfos_cmd_t cmd
);
  import jfos_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r == ST_EXEC);
  assign cmd.capture = (state_r == ST_IDLE) && start;
  assign cmd.execute = (state_r == ST_EXEC);

endmodule : jfos_ctrl

`default_nettype wire

### design/jfos_dpath.sv
// ----------------------------------------------------------------------------
// jfos_dpath
// Operand stack and local variable register files, limit checks and the
// registered result of one operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jfos_dpath (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  jfos_pkg::jfos_cmd_t       cmd,
  input  wire  [2:0]                      in_mode,
  input  wire  signed [jfos_pkg::VAL_W-1:0] in_value,
  input  wire  [jfos_pkg::TAG_W-1:0]      in_type_tag,
  input  wire  [3:0]                      in_slot,
  input  wire  [jfos_pkg::CFG_W-1:0]      local_count,
  input  wire  [jfos_pkg::CFG_W-1:0]      stack_limit,
  output logic                            out_valid,
  output logic signed [jfos_pkg::VAL_W-1:0] out_result_value,
  output logic [jfos_pkg::TAG_W-1:0]      out_result_tag,
  output logic [4:0]                      out_depth,
  output logic [1:0]                      out_error
);
  import jfos_pkg::*;

  // Latched operation.
  logic [2:0]       mode_r;
  logic [VAL_W-1:0] value_r;
  logic [TAG_W-1:0] tag_r;
  logic [3:0]       slot_r;

  // Register files. Locals carry a valid bit so that an unwritten slot reads
  // as zero without a clearing pass.
  logic [VAL_W-1:0] stk_val_r [STACK_DEPTH];
  logic [TAG_W-1:0] stk_tag_r [STACK_DEPTH];
  logic [VAL_W-1:0] loc_val_r [LOCAL_SLOTS];
  logic [TAG_W-1:0] loc_tag_r [LOCAL_SLOTS];
  logic [LOCAL_SLOTS-1:0] loc_vld_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_nxt;

  logic [CMP_W-1:0] lim_eff;
  logic [CMP_W-1:0] loc_eff;
  logic             full;
  logic             empty;
  logic             bad_slot;
  logic [SIDX_W-1:0] push_idx;
  logic [SIDX_W-1:0] top_idx;
  logic [LIDX_W-1:0] loc_idx;
  logic [VAL_W-1:0] top_val;
  logic [TAG_W-1:0] top_tag;
  logic [VAL_W-1:0] loc_val;
  logic [TAG_W-1:0] loc_tag;

  logic             push_en;
  logic             store_en;
  logic [VAL_W-1:0] res_val;
  logic [TAG_W-1:0] res_tag;
  logic [1:0]       res_err;

  always_comb begin
    lim_eff = ({{(CMP_W-CFG_W){1'b0}}, stack_limit} > CMP_W'(STACK_DEPTH))
              ? CMP_W'(STACK_DEPTH) : {{(CMP_W-CFG_W){1'b0}}, stack_limit};
    loc_eff = ({{(CMP_W-CFG_W){1'b0}}, local_count} > CMP_W'(LOCAL_SLOTS))
              ? CMP_W'(LOCAL_SLOTS) : {{(CMP_W-CFG_W){1'b0}}, local_count};
  end

  assign full     = CMP_W'(depth_r) >= lim_eff;
  assign empty    = (depth_r == '0);
  assign bad_slot = CMP_W'(slot_r) >= loc_eff;

  // A push only happens below the limit, so depth_r fits the index there.
  assign push_idx = SIDX_W'(depth_r);
  assign top_idx  = SIDX_W'(depth_r - DEPTH_W'(1));
  assign loc_idx  = LIDX_W'(slot_r);

  assign top_val = stk_val_r[top_idx];
  assign top_tag = stk_tag_r[top_idx];
  assign loc_val = loc_vld_r[loc_idx] ? loc_val_r[loc_idx] : '0;
  assign loc_tag = loc_vld_r[loc_idx] ? loc_tag_r[loc_idx] : '0;

  always_comb begin
    push_en   = 1'b0;
    store_en  = 1'b0;
    res_val   = '0;
    res_tag   = '0;
    res_err   = ERR_OK;
    depth_nxt = depth_r;
    unique case (mode_r)
      MODE_PUSH, MODE_PUSHOB: begin
        if (full) begin
          res_err = ERR_OVER;
        end else begin
          push_en = 1'b1;
          res_val = value_r;
          res_tag = (mode_r == MODE_PUSHOB) ? TAG_OBJECT : tag_r;
        end
      end
      MODE_POP: begin
        if (empty) begin
          res_err = ERR_UNDER;
        end else begin
          depth_nxt = depth_r - DEPTH_W'(1);
          res_val   = top_val;
          res_tag   = top_tag;
        end
      end
      MODE_DUP: begin
        if (empty) begin
          res_err = ERR_UNDER;
        end else if (full) begin
          res_err = ERR_OVER;
        end else begin
          push_en = 1'b1;
          res_val = top_val;
          res_tag = top_tag;
        end
      end
      MODE_LOAD: begin
        if (full) begin
          res_err = ERR_OVER;
        end else if (bad_slot) begin
          res_err = ERR_SLOT;
        end else begin
          push_en = 1'b1;
          res_val = loc_val;
          res_tag = loc_tag;
        end
      end
      MODE_STORE: begin
        if (empty) begin
          res_err = ERR_UNDER;
        end else if (bad_slot) begin
          res_err = ERR_SLOT;
        end else begin
          store_en  = 1'b1;
          depth_nxt = depth_r - DEPTH_W'(1);
          res_val   = top_val;
          res_tag   = top_tag;
        end
      end
      MODE_READ: begin
        if (bad_slot) begin
          res_err = ERR_SLOT;
        end else begin
          res_val = loc_val;
          res_tag = loc_tag;
        end
      end
      MODE_NOP: begin
      end
      default: begin
      end
    endcase
    if (push_en) depth_nxt = depth_r + DEPTH_W'(1);
  end

  // Operation capture, register file writes and the result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      value_r <= in_value;
      tag_r   <= in_type_tag;
      slot_r  <= in_slot;
    end
    if (cmd.execute && push_en) begin
      stk_val_r[push_idx] <= res_val;
      stk_tag_r[push_idx] <= res_tag;
    end
    if (cmd.execute && store_en) begin
      loc_val_r[loc_idx] <= res_val;
      loc_tag_r[loc_idx] <= res_tag;
    end
    if (cmd.execute) begin
      out_result_value <= res_val;
      out_result_tag   <= res_tag;
      out_depth        <= 5'(depth_nxt);
      out_error        <= res_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= '0;
      loc_vld_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.execute;
      if (cmd.execute) depth_r <= depth_nxt;
      if (cmd.execute && store_en) loc_vld_r[loc_idx] <= 1'b1;
    end
  end

endmodule : jfos_dpath

`default_nettype wire

### design/jvm_frame_operand_stack_unit.sv
// ----------------------------------------------------------------------------
// jvm_frame_operand_stack_unit
// Typed operand stack and local variable file of one method frame, with a
// register port for the slot count and the stack limit.
// ----------------------------------------------------------------------------
// Sequence: start latches the operation, the execute state performs it and
// out_valid is registered from it. No start is taken while busy is high,
// in the execute cycle in which the register files are read and written.
// Reset: depth goes to zero, all locals read as zero, local_count and
// stack_limit go to 16. The receiver cannot stall; each result shows once.
`timescale 1ns / 1ps
`default_nettype none

module jvm_frame_operand_stack_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire  [2:0]                      in_mode,
  input  wire  signed [jfos_pkg::VAL_W-1:0] in_value,
  input  wire  [jfos_pkg::TAG_W-1:0]      in_type_tag,
  input  wire  [3:0]                      in_slot,
  output logic                            out_valid,
  output logic signed [jfos_pkg::VAL_W-1:0] out_result_value,
  output logic [jfos_pkg::TAG_W-1:0]      out_result_tag,
  output logic [4:0]                      out_depth,
  output logic [1:0]                      out_error,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [2:0]                      paddr,
  input  wire  [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import jfos_pkg::*;

  jfos_cmd_t        cmd;
  logic [CFG_W-1:0] local_count_r;
  logic [CFG_W-1:0] stack_limit_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Registers sit on word addresses; the low address bits are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_count_r <= CFG_W'(16);
      stack_limit_r <= CFG_W'(16);
    end else if (wr_en) begin
      if (paddr[2] == REG_LOCAL_COUNT) local_count_r <= pwdata[CFG_W-1:0];
      if (paddr[2] == REG_STACK_LIMIT) stack_limit_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_LOCAL_COUNT: prdata[CFG_W-1:0] = local_count_r;
      REG_STACK_LIMIT: prdata[CFG_W-1:0] = stack_limit_r;
      default:         prdata = '0;
    endcase
  end

  jfos_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  jfos_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .in_type_tag      (in_type_tag),
    .in_slot          (in_slot),
    .local_count      (local_count_r),
    .stack_limit      (stack_limit_r),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_result_tag   (out_result_tag),
    .out_depth        (out_depth),
    .out_error        (out_error)
  );

endmodule : jvm_frame_operand_stack_unit

`default_nettype wire

### design/jfos_checker.sv
// ----------------------------------------------------------------------------
// jfos_checker
// Port-level checks of the operand stack unit's sequencing and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jfos_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_valid,
  input wire [63:0] out_result_value,
  input wire [3:0]  out_result_tag,
  input wire [4:0]  out_depth,
  input wire [1:0]  out_error
);
  import jfos_pkg::*;

  // An accepted transfer occupies the unit for exactly one execute cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted operation did not raise busy");

  // Every execute cycle is followed by exactly one result.
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execute cycle not followed by a result");

  // A result only follows an execute cycle.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an operation");

  // A failed operation returns zero and leaves the depth in range.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error != ERR_OK)) |->
      ((out_result_value == '0) && (out_result_tag == '0)))
    else $error("failed operation returned data");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_depth <= 5'(STACK_DEPTH)))
    else $error("depth beyond stack size");

endmodule : jfos_checker

bind jvm_frame_operand_stack_unit jfos_checker u_jfos_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_result_value (out_result_value),
  .out_result_tag   (out_result_tag),
  .out_depth        (out_depth),
  .out_error        (out_error)
);

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame operand stack unit. A scoreboard class
// keeps its own copy of the stack, the locals and both registers, works out
// the result of every accepted operation and compares it with the strobed
// result. Directed cases cover the empty, full and bad-slot corners, then
// random phases run under several register settings with random sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import jfos_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 105;
  localparam int PHASE_COUNT  = 8;

  typedef struct {
    logic [63:0] value;
    logic [3:0]  tag;
    logic [4:0]  depth;
    logic [1:0]  error;
  } frame_result_t;

  class frame_scoreboard;
    logic [63:0]   stk_val [STACK_DEPTH];
    logic [3:0]    stk_tag [STACK_DEPTH];
    logic [63:0]   loc_val [LOCAL_SLOTS];
    logic [3:0]    loc_tag [LOCAL_SLOTS];
    int            depth;
    logic [4:0]    local_count;
    logic [4:0]    stack_limit;
    frame_result_t pending_results [$];
    int            fail_count;

    function new();
      for (int i = 0; i < LOCAL_SLOTS; i++) begin
        loc_val[i] = '0;
        loc_tag[i] = '0;
      end
      depth       = 0;
      local_count = 5'd16;
      stack_limit = 5'd16;
      fail_count  = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] data);
      if (idx == REG_LOCAL_COUNT) local_count = data[4:0];
      else stack_limit = data[4:0];
    endfunction

    // Applies one accepted operation to the frame copy and queues its result.
    function void note_op(logic [2:0] mode, logic [63:0] value, logic [3:0] tag,
                          logic [3:0] slot);
      frame_result_t r;
      int            lim;
      int            slots;
      bit            full;
      bit            bad_slot;
      lim      = (stack_limit > STACK_DEPTH) ? STACK_DEPTH : int'(stack_limit);
      slots    = (local_count > LOCAL_SLOTS) ? LOCAL_SLOTS : int'(local_count);
      full     = depth >= lim;
      bad_slot = int'(slot) >= slots;
      r.value  = '0;
      r.tag    = '0;
      r.error  = ERR_OK;
      case (mode)
        MODE_PUSH, MODE_PUSHOB: begin
          if (full) r.error = ERR_OVER;
          else begin
            r.value = value;
            r.tag   = (mode == MODE_PUSHOB) ? TAG_OBJECT : tag;
          end
        end
        MODE_POP: begin
          if (depth == 0) r.error = ERR_UNDER;
          else begin
            depth   = depth - 1;
            r.value = stk_val[depth];
            r.tag   = stk_tag[depth];
          end
        end
        MODE_DUP: begin
          if (depth == 0) r.error = ERR_UNDER;
          else if (full) r.error = ERR_OVER;
          else begin
            r.value = stk_val[depth-1];
            r.tag   = stk_tag[depth-1];
          end
        end
        MODE_LOAD: begin
          if (full) r.error = ERR_OVER;
          else if (bad_slot) r.error = ERR_SLOT;
          else begin
            r.value = loc_val[slot];
            r.tag   = loc_tag[slot];
          end
        end
        MODE_STORE: begin
          if (depth == 0) r.error = ERR_UNDER;
          else if (bad_slot) r.error = ERR_SLOT;
          else begin
            depth         = depth - 1;
            r.value       = stk_val[depth];
            r.tag         = stk_tag[depth];
            loc_val[slot] = r.value;
            loc_tag[slot] = r.tag;
          end
        end
        MODE_READ: begin
          if (bad_slot) r.error = ERR_SLOT;
          else begin
            r.value = loc_val[slot];
            r.tag   = loc_tag[slot];
          end
        end
        default: ;
      endcase
      // Pushing modes share the final write of the new top entry.
      if (r.error == ERR_OK && (mode == MODE_PUSH || mode == MODE_PUSHOB ||
                                mode == MODE_DUP || mode == MODE_LOAD)) begin
        stk_val[depth] = r.value;
        stk_tag[depth] = r.tag;
        depth          = depth + 1;
      end
      r.depth = depth[4:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [63:0] value, logic [3:0] tag, logic [4:0] dep,
                               logic [1:0] error);
      frame_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: value %h tag %0d depth %0d error %0d",
                 $time, value, tag, dep, error);
        fail_count++;
        return;
      end
      e = pending_results.pop_front();
      if (value !== e.value) begin
        $display("%0t: result_value expected %h actual %h", $time, e.value, value);
        fail_count++;
      end
      if (tag !== e.tag) begin
        $display("%0t: result_tag expected %0d actual %0d", $time, e.tag, tag);
        fail_count++;
      end
      if (dep !== e.depth) begin
        $display("%0t: depth expected %0d actual %0d", $time, e.depth, dep);
        fail_count++;
      end
      if (error !== e.error) begin
        $display("%0t: error expected %0d actual %0d", $time, e.error, error);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_mode;
  logic [63:0] in_value;
  logic [3:0]  in_type_tag;
  logic [3:0]  in_slot;
  logic        out_valid;
  logic [63:0] out_result_value;
  logic [3:0]  out_result_tag;
  logic [4:0]  out_depth;
  logic [1:0]  out_error;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb;
  int              idle_cycles;
  bit              burst;

  jvm_frame_operand_stack_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .in_type_tag      (in_type_tag),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_result_tag   (out_result_tag),
    .out_depth        (out_depth),
    .out_error        (out_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Input transfers are noted before results are checked, in one process.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_op(in_mode, in_value, in_type_tag, in_slot);
      if (out_valid) sb.check_result(out_result_value, out_result_tag, out_depth, out_error);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL jvm_frame_operand_stack_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 64'h7FFF_FFFF_FFFF_FFFF;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h0;
      3: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [2:0] pick_mode(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return ($urandom_range(0, 1) == 0) ? MODE_PUSH : MODE_PUSHOB;
    r = $urandom_range(0, 99);
    if (r < 25) return MODE_POP;
    if (r < 40) return MODE_DUP;
    if (r < 60) return MODE_LOAD;
    if (r < 80) return MODE_STORE;
    if (r < 97) return MODE_READ;
    return MODE_NOP;
  endfunction

  task automatic send_op(input logic [2:0] mode, input logic [63:0] value,
                         input logic [3:0] tag, input logic [3:0] slot);
    int gap;
    if ($urandom_range(0, 7) == 0) burst = ~burst;
    gap = burst ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      start       = 1'b0;
      in_mode     = 3'($urandom);
      in_value    = {$urandom, $urandom};
      in_type_tag = 4'($urandom);
      in_slot     = 4'($urandom);
    end
    @(negedge clk);
    start       = 1'b1;
    in_mode     = mode;
    in_value    = value;
    in_type_tag = tag;
    in_slot     = slot;
    do @(posedge clk); while (busy);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic run_phase(input logic [4:0] lc, input logic [4:0] sl, input int push_pct);
    logic [31:0] junk;
    drain();
    junk = ($urandom_range(0, 1) == 0) ? 32'h0 : ($urandom & 32'hFFFF_FFE0);
    cfg_write(REG_LOCAL_COUNT, junk | lc);
    cfg_write(REG_STACK_LIMIT, junk | sl);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 0) drain();
      send_op(pick_mode(push_pct), rand_value(), 4'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    sb          = new();
    idle_cycles = 0;
    burst       = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_mode     = '0;
    in_value    = '0;
    in_type_tag = '0;
    in_slot     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty stack and freshly cleared locals.
    send_op(MODE_POP, 64'h0, 4'd0, 4'd0);
    send_op(MODE_DUP, 64'h0, 4'd0, 4'd0);
    send_op(MODE_STORE, 64'h0, 4'd0, 4'd0);
    send_op(MODE_READ, 64'h0, 4'd0, 4'd15);
    send_op(MODE_LOAD, 64'h0, 4'd0, 4'd3);
    send_op(MODE_PUSH, 64'h7FFF_FFFF_FFFF_FFFF, 4'd15, 4'd0);
    send_op(MODE_PUSH, 64'h8000_0000_0000_0000, 4'd0, 4'd0);
    send_op(MODE_PUSHOB, '1, 4'd10, 4'd5);
    send_op(MODE_DUP, 64'h0, 4'd0, 4'd0);
    send_op(MODE_STORE, 64'h0, 4'd0, 4'd15);
    send_op(MODE_READ, 64'h0, 4'd0, 4'd15);
    send_op(MODE_POP, 64'h0, 4'd0, 4'd0);
    send_op(MODE_NOP, '1, 4'd15, 4'd15);
    drain();

    // Limit lowered below the current depth and only two slots in use.
    cfg_write(REG_STACK_LIMIT, 32'd2);
    cfg_write(REG_LOCAL_COUNT, 32'd2);
    send_op(MODE_PUSH, 64'h1234, 4'd2, 4'd0);
    send_op(MODE_DUP, 64'h0, 4'd0, 4'd0);
    send_op(MODE_LOAD, 64'h0, 4'd0, 4'd9);
    send_op(MODE_STORE, 64'h0, 4'd0, 4'd2);
    send_op(MODE_READ, 64'h0, 4'd0, 4'd1);
    send_op(MODE_STORE, 64'h0, 4'd0, 4'd1);
    drain();

    // Zero in both registers: every push overflows, every slot is out of range.
    cfg_write(REG_STACK_LIMIT, 32'd0);
    cfg_write(REG_LOCAL_COUNT, 32'd0);
    send_op(MODE_PUSHOB, 64'h55, 4'd0, 4'd0);
    send_op(MODE_READ, 64'h0, 4'd0, 4'd0);
    send_op(MODE_STORE, 64'h0, 4'd0, 4'd0);

    run_phase(5'd16, 5'd16, 45);
    run_phase(5'd1, 5'd1, 40);
    run_phase(5'd31, 5'd31, 55);
    run_phase(5'd0, 5'd16, 50);
    run_phase(5'd16, 5'd0, 40);
    run_phase(5'd5, 5'd9, 45);
    for (int p = 6; p < PHASE_COUNT; p++) begin
      run_phase(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                $urandom_range(30, 60));
    end

    drain();
    repeat (5) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("PASS jvm_frame_operand_stack_unit");
    end else begin
      $display("FAIL jvm_frame_operand_stack_unit");
    end
    $finish;
  end

endmodule

### filelist.f
design/jfos_pkg.sv
design/jfos_ctrl.sv
design/jfos_dpath.sv
design/jvm_frame_operand_stack_unit.sv
design/jfos_checker.sv
sim/testbench.sv
